>>> hw/rtl/hse_pkg.sv
// ----------------------------------------------------------------------------
// hse_pkg
// Shared types and constants for the heap sort engine: key width, the
// controller state encoding and the control word sent down the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package hse_pkg;

  localparam int unsigned KEY_W = 32;

  typedef logic signed [KEY_W-1:0] key_t;

  // Controller states, one-hot.
  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

  // Control word broadcast to every cell.
  typedef struct packed {
    logic load;   // insert the broadcast key in sorted position
    logic shift;  // move every key one cell toward the head
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/hse_cell.sv
// ----------------------------------------------------------------------------
// hse_cell
// One cell of the sorting chain. Holds one key and its valid bit; inserts a
// broadcast key in ascending order or shifts toward the head.
// ----------------------------------------------------------------------------
`default_nettype none

module hse_cell (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  hse_pkg::cell_ctrl_t     ctrl_i,
  input  hse_pkg::key_t           new_key_i,
  input  hse_pkg::key_t           prev_key_i,
  input  wire                     prev_valid_i,
  input  wire                     prev_lt_i,
  input  hse_pkg::key_t           next_key_i,
  input  wire                     next_valid_i,
  output hse_pkg::key_t           key_o,
  output logic                    valid_o,
  output logic                    lt_o
);

  hse_pkg::key_t key_q, key_d;
  logic          valid_q, valid_d;

  // Empty cells act as plus infinity.
  assign lt_o = !valid_q || (new_key_i < key_q);

  always_comb begin
    key_d   = key_q;
    valid_d = valid_q;
    if (ctrl_i.shift) begin
      key_d   = next_key_i;
      valid_d = next_valid_i;
    end else if (ctrl_i.load && lt_o) begin
      if (prev_lt_i) begin
        key_d   = prev_key_i;
        valid_d = prev_valid_i;
      end else begin
        key_d   = new_key_i;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o   = key_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

>>> hw/rtl/heap_sort_engine_unit.sv
// ----------------------------------------------------------------------------
// heap_sort_engine_unit
// Collects a set of signed keys and returns them in ascending order.
// ----------------------------------------------------------------------------
// Keys arrive one word per cycle while loading and are inserted in sorted
// position into a chain of CAPACITY cells, one key per cell; every cell
// compares the new key with its own in parallel. The word marked final closes
// the set. The chain then drains from its head, one sorted word per cycle
// while the output side does not stall, with final_out_o on the last word and
// keys_dropped_o set on every word of a set in which keys arrived after the
// chain was full (those keys are discarded, the final one included). While
// draining, the input is stalled. The parallel insert across the cell chain
// sets the load rate and the shift of the chain toward its head, whose cell
// drives the output, sets the drain rate. No clearing pass after reset:
// draining leaves every cell empty.
// ----------------------------------------------------------------------------
`default_nettype none

module heap_sort_engine_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // input words
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  hse_pkg::key_t         key_value_i,
  input  wire                   is_final_i,
  // result words
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output hse_pkg::key_t         sorted_key_o,
  output logic                  final_out_o,
  output logic                  keys_dropped_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  hse_pkg::state_e     state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                ovf_q, ovf_d;

  logic                in_acc;
  logic                out_acc;
  logic                room;
  hse_pkg::cell_ctrl_t ctrl;

  hse_pkg::key_t       cell_key   [CAPACITY];
  logic                cell_valid [CAPACITY];
  logic                cell_lt    [CAPACITY];

  // Accept input only while loading; hold results until taken.
  assign in_stall_o = (state_q != hse_pkg::ST_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == hse_pkg::ST_DRAIN);
  assign out_acc    = out_valid_o && !out_stall_i;
  assign room       = (count_q < CNT_W'(CAPACITY));

  assign ctrl.load  = in_acc && room;
  assign ctrl.shift = out_acc;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    unique case (state_q)
      hse_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (room) begin
            count_d = count_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (is_final_i) begin
            state_d = hse_pkg::ST_DRAIN;
          end
        end
      end
      hse_pkg::ST_DRAIN: begin
        if (out_acc) begin
          count_d = count_q - CNT_W'(1);
          // Last word gone: reopen for the next set.
          if (count_q == CNT_W'(1)) begin
            ovf_d   = 1'b0;
            state_d = hse_pkg::ST_LOAD;
          end
        end
      end
      default: begin
        state_d = hse_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hse_pkg::ST_LOAD;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  // Cell chain: cell 0 holds the smallest key and feeds the output.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    hse_pkg::key_t prev_key, next_key;
    logic          prev_valid, prev_lt, next_valid;

    if (i == 0) begin : g_head
      assign prev_key   = '0;
      assign prev_valid = 1'b0;
      assign prev_lt    = 1'b0;
    end else begin : g_body
      assign prev_key   = cell_key[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_lt    = cell_lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_key   = '0;
      assign next_valid = 1'b0;
    end else begin : g_link
      assign next_key   = cell_key[i+1];
      assign next_valid = cell_valid[i+1];
    end

    hse_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_key_i    (key_value_i),
      .prev_key_i   (prev_key),
      .prev_valid_i (prev_valid),
      .prev_lt_i    (prev_lt),
      .next_key_i   (next_key),
      .next_valid_i (next_valid),
      .key_o        (cell_key[i]),
      .valid_o      (cell_valid[i]),
      .lt_o         (cell_lt[i])
    );
  end

  assign sorted_key_o   = cell_key[0];
  assign final_out_o    = (count_q == CNT_W'(1));
  assign keys_dropped_o = ovf_q;

endmodule

`default_nettype wire

>>> tb/sort_order_checker.sv
// ----------------------------------------------------------------------------
// sort_order_checker
// Watches both channels of the heap sort engine and checks every result word.
// ----------------------------------------------------------------------------
// Mirrors the key set of the engine: each accepted input word adds a key, or
// marks the set as overflowed when the store is full. On the word flagged
// final, the set is sorted ascending and queued as expected result words.
// Each accepted result word is checked field by field against the oldest one.
// ----------------------------------------------------------------------------
`default_nettype none

module sort_order_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  input  wire                   in_stall_i,
  input  hse_pkg::key_t         key_value_i,
  input  wire                   is_final_i,
  input  wire                   out_valid_i,
  input  wire                   out_stall_i,
  input  hse_pkg::key_t         sorted_key_i,
  input  wire                   final_out_i,
  input  wire                   keys_dropped_i,
  output logic                  busy_o,
  output int unsigned           errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    hse_pkg::key_t key;
    logic          last;
    logic          dropped;
  } sorted_word_t;

  hse_pkg::key_t set_keys [CAPACITY];
  int unsigned   set_len;
  logic          set_overflow;
  sorted_word_t  sorted_words_q [$];
  int unsigned   mismatch_cnt;

  // Sort the collected keys ascending and queue one result word per key.
  function automatic void close_set();
    hse_pkg::key_t k;
    int            j;
    sorted_word_t  w;
    for (int i = 1; i < int'(set_len); i++) begin
      k = set_keys[i];
      j = i;
      while (j > 0 && set_keys[j-1] > k) begin
        set_keys[j] = set_keys[j-1];
        j--;
      end
      set_keys[j] = k;
    end
    for (int unsigned i = 0; i < set_len; i++) begin
      w.key     = set_keys[i];
      w.last    = (i + 1 == set_len);
      w.dropped = set_overflow;
      sorted_words_q.push_back(w);
    end
    set_len      = 0;
    set_overflow = 1'b0;
  endfunction

  function automatic void note_mismatch(input string what);
    if (mismatch_cnt < 10) $display("mismatch at %0t: %s", $realtime, what);
    mismatch_cnt++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    sorted_word_t want;
    if (!rst_ni) begin
      set_len      = 0;
      set_overflow = 1'b0;
      mismatch_cnt = 0;
      sorted_words_q.delete();
      busy_o   <= 1'b0;
      errors_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        if (set_len < CAPACITY) begin
          set_keys[set_len] = key_value_i;
          set_len++;
        end else begin
          set_overflow = 1'b1;
        end
        if (is_final_i) close_set();
      end
      if (out_valid_i && !out_stall_i) begin
        if (sorted_words_q.size() == 0) begin
          note_mismatch($sformatf("unexpected word key=%0d last=%0b dropped=%0b",
                                  sorted_key_i, final_out_i, keys_dropped_i));
        end else begin
          want = sorted_words_q.pop_front();
          if (sorted_key_i !== want.key || final_out_i !== want.last ||
              keys_dropped_i !== want.dropped)
            note_mismatch($sformatf(
              "expected key=%0d last=%0b dropped=%0b, got key=%0d last=%0b dropped=%0b",
              want.key, want.last, want.dropped,
              sorted_key_i, final_out_i, keys_dropped_i));
        end
      end
      busy_o   <= (sorted_words_q.size() != 0);
      errors_o <= mismatch_cnt;
    end
  end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the heap sort engine.
// ----------------------------------------------------------------------------
// Sends key sets to the engine and lets sort_order_checker judge the sorted
// words. A short directed part covers extreme keys, single-key sets, equal
// keys and presorted orders; a random part sends mostly small sets with a
// full store and an overflowing store mixed in. Both sides idle in random
// bursts until the closing stretch, which runs at full rate.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY        = 64;
  localparam int unsigned SMALL_SET_WORDS = 32;   // words sent in small random sets
  localparam int unsigned QUIET_AFTER     = 24;   // no idling from here on
  localparam int unsigned IDLE_LIMIT      = 20000;
  localparam int unsigned SETTLE_CYCLES   = 40;

  localparam hse_pkg::key_t KEY_MAX = hse_pkg::key_t'(32'h7fff_ffff);
  localparam hse_pkg::key_t KEY_MIN = hse_pkg::key_t'(32'h8000_0000);

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  hse_pkg::key_t key_value;
  logic          is_final;
  logic          out_valid;
  logic          out_stall;
  hse_pkg::key_t sorted_key;
  logic          final_out;
  logic          keys_dropped;
  logic          busy;
  int unsigned   errors;
  bit            quiet = 1'b0;
  int unsigned   idle_cycles = 0;

  heap_sort_engine_unit #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .key_value_i   (key_value),
    .is_final_i    (is_final),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .sorted_key_o  (sorted_key),
    .final_out_o   (final_out),
    .keys_dropped_o(keys_dropped)
  );

  sort_order_checker #(
    .CAPACITY(CAPACITY)
  ) u_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .key_value_i   (key_value),
    .is_final_i    (is_final),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .sorted_key_i  (sorted_key),
    .final_out_i   (final_out),
    .keys_dropped_i(keys_dropped),
    .busy_o        (busy),
    .errors_o      (errors)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hold reset low from the start, then release it for good.
  initial begin
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Pick a key: mostly full-range, sometimes the extremes, sometimes a narrow
  // band so that equal keys show up within a set.
  function automatic hse_pkg::key_t pick_key();
    case ($urandom_range(0, 5))
      0:       return ($urandom_range(0, 1) != 0) ? KEY_MAX : KEY_MIN;
      1, 2:    return hse_pkg::key_t'(int'($urandom_range(0, 8)) - 4);
      default: return hse_pkg::key_t'($urandom);
    endcase
  endfunction

  // Drop valid and idle.
  task automatic hold_off(input int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Offer one word and wait for it to be taken. Valid stays high afterwards so
  // back-to-back words go out without a bubble; hold_off lowers it.
  task automatic send_word(input hse_pkg::key_t k, input logic last);
    if (!quiet && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 12));
    in_valid  <= 1'b1;
    key_value <= k;
    is_final  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_set(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_word(pick_key(), i == n - 1);
  endtask

  // Stop sending and wait until every expected word has come back. The first
  // edge lets the checker register the set that was just closed.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Result side: alternate stall and free bursts, sometimes long free
  // stretches; stop stalling once the closing stretch starts.
  initial begin : result_side
    int unsigned n;
    out_stall <= 1'b0;
    forever begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        out_stall <= (n <= 12) && ($urandom_range(0, 2) == 0);
        repeat (n) @(posedge clk);
      end
    end
  end

  // Watchdog: end the run if neither channel moves a word for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned small_words;
    int unsigned set_no;
    int unsigned n;
    in_valid  <= 1'b0;
    key_value <= '0;
    is_final  <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);

    // Single-key sets at both extremes.
    send_word(KEY_MAX, 1'b1);
    send_word(KEY_MIN, 1'b1);
    // Extremes, zero and both signs around it, with a repeated key.
    send_word(32'sd0, 1'b0);
    send_word(-32'sd1, 1'b0);
    send_word(32'sd1, 1'b0);
    send_word(KEY_MIN, 1'b0);
    send_word(KEY_MAX, 1'b0);
    send_word(-32'sd1, 1'b1);
    // Two equal keys.
    send_word(32'sd5, 1'b0);
    send_word(32'sd5, 1'b1);
    // Keys arriving in descending, then in ascending order.
    send_word(32'sd100, 1'b0);
    send_word(32'sd50, 1'b0);
    send_word(-32'sd50, 1'b0);
    send_word(-32'sd100, 1'b1);
    send_word(-32'sd3, 1'b0);
    send_word(-32'sd2, 1'b0);
    send_word(-32'sd1, 1'b0);
    send_word(32'sd0, 1'b1);
    // Hold the input until the engine has emptied.
    wait_for_drain();

    // Random sets, mostly small. One set fills the store exactly, another
    // runs past it so that keys, the final one included, are discarded.
    small_words = 0;
    set_no      = 0;
    while (small_words < SMALL_SET_WORDS || set_no <= 5) begin
      if (set_no == 2) begin
        send_set(CAPACITY);
      end else if (set_no == 5) begin
        send_set(CAPACITY + 2);
        wait_for_drain();
      end else begin
        n = $urandom_range(1, 10);
        send_set(n);
        small_words += n;
      end
      set_no++;
      if (small_words >= QUIET_AFTER) quiet = 1'b1;
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
